// ===== hw/rtl/assert_macros.svh =====
// Assertion macros included by the RTL of the hosts record line parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked property, switched off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property, evaluated on every edge including during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/hrlp_pkg.sv =====
// Types and constants of the hosts record line parser.
package hrlp_pkg;

  // Parse phase of the running record.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ADDR = 2'd1,
    PH_NAME = 2'd2
  } phase_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_EOF     = 2'd2
  } status_t;

  // Running state of one record.
  typedef struct packed {
    phase_t      phase;
    logic [31:0] addr;
    logic [15:0] grp;
    logic [1:0]  dots;
    logic        grp_nonempty;
    logic [7:0]  name_len;
    logic [6:0]  labels;
    logic        prev_dot;
    logic        err;
  } rec_state_t;

  localparam rec_state_t REC_CLEAR = '0;

  // Character codes.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Limits.
  localparam logic [1:0] LAST_DOT   = 2'd3;
  localparam logic [7:0] MAX_LEN    = 8'd255;
  localparam logic [6:0] MAX_LABELS = 7'd127;

endpackage

// ===== hw/rtl/hrlp_if.sv =====
// Valid/ready channel interfaces for bytes in and records out.
interface hrlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       buffer_last;

  modport source (output valid, text_byte, buffer_last, input ready);
  modport sink (input valid, text_byte, buffer_last, output ready);
endinterface

interface hrlp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] ipv4_address;
  logic [7:0]  name_length;
  logic [6:0]  label_count;

  modport source (output valid, status, ipv4_address, name_length, label_count,
                  input ready);
  modport sink (input valid, status, ipv4_address, name_length, label_count,
                output ready);
endinterface

// ===== hw/rtl/hosts_record_line_parser.sv =====
// Hosts record line parser: bytes of "a.b.c.d name" lines in, one record per line out.
//
// The in_chan channel carries one text byte per request, with buffer_last set on
// the final byte of a buffer. The out_chan channel carries one record per request:
// status (okay, invalid, end of buffer), the IPv4 address, the name length and the
// label count; the value fields are zero unless the status is okay.
// A request is taken at a rising edge with valid and ready both high.
// Throughput is one byte per cycle while no result waits on the receiver. A byte is
// held in the input register; the per-byte update of the record state and the result
// are formed from it combinationally and captured in the output register, which
// offers it. Bytes that produce no result (neither a record's closing byte nor a
// buffer's final byte) pass without waiting on the receiver; a byte that produces a
// result waits only while the output register is full and not being taken, and no
// further byte is taken while it waits. Line ends between records are skipped.
// Synchronous active-low reset empties both registers and returns the parser to
// between records; no clearing pass is needed.
module hosts_record_line_parser (
  input  logic              clk,
  input  logic              rst_n,
  hrlp_in_if.sink           in_chan,
  hrlp_out_if.source        out_chan
);

  `include "assert_macros.svh"

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // Record state.
  hrlp_pkg::rec_state_t state_r, state_nxt, work;

  // Output register.
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [31:0] out_addr_r;
  logic [7:0]  out_len_r;
  logic [6:0]  out_labels_r;

  logic        eol, is_digit, label_start;
  logic [15:0] grp_times10;
  logic        fin, emit, rec_ok, out_free, s1_fire;
  logic [1:0]  res_status;
  logic [31:0] res_addr;
  logic [7:0]  res_len;
  logic [6:0]  res_labels;

  assign eol = (s1_byte_r == hrlp_pkg::CH_LF) || (s1_byte_r == hrlp_pkg::CH_CR);
  assign is_digit = (s1_byte_r >= hrlp_pkg::CH_ZERO) && (s1_byte_r <= hrlp_pkg::CH_NINE);
  assign grp_times10 = {state_r.grp[12:0], 3'b000} + {state_r.grp[14:0], 1'b0};

  // Per-byte update of the record state, before the record is closed.
  always_comb begin
    work = state_r;
    label_start = (state_r.name_len == 8'd0) || state_r.prev_dot;
    if ((state_r.phase == hrlp_pkg::PH_IDLE) && !eol) begin
      work = hrlp_pkg::REC_CLEAR;
      work.phase = hrlp_pkg::PH_ADDR;
    end
    if (!eol && !work.err) begin
      case (work.phase)
        hrlp_pkg::PH_ADDR: begin
          if (is_digit) begin
            work.grp = work.grp_nonempty
                     ? grp_times10 + {12'd0, s1_byte_r[3:0]}
                     : {12'd0, s1_byte_r[3:0]};
            work.grp_nonempty = 1'b1;
          end else if (s1_byte_r == hrlp_pkg::CH_DOT) begin
            if (!work.grp_nonempty || (work.dots == hrlp_pkg::LAST_DOT)) begin
              work.err = 1'b1;
            end else begin
              work.addr = {work.addr[23:0], 8'd0} + {16'd0, work.grp};
              work.dots = work.dots + 2'd1;
              work.grp = 16'd0;
              work.grp_nonempty = 1'b0;
            end
          end else if (s1_byte_r == hrlp_pkg::CH_SPACE) begin
            if ((work.dots != hrlp_pkg::LAST_DOT) || !work.grp_nonempty || s1_last_r) begin
              work.err = 1'b1;
            end else begin
              work.addr = {work.addr[23:0], 8'd0} + {16'd0, work.grp};
              work.grp = 16'd0;
              work.grp_nonempty = 1'b0;
              work.phase = hrlp_pkg::PH_NAME;
              work.name_len = 8'd0;
              work.labels = 7'd0;
              work.prev_dot = 1'b0;
            end
          end else begin
            work.err = 1'b1;
          end
        end
        hrlp_pkg::PH_NAME: begin
          if (s1_byte_r == hrlp_pkg::CH_DOT) begin
            if (label_start) begin
              work.err = 1'b1;
            end
            work.prev_dot = 1'b1;
          end else begin
            if (label_start && (work.labels != hrlp_pkg::MAX_LABELS)) begin
              work.labels = work.labels + 7'd1;
            end
            work.prev_dot = 1'b0;
          end
          if (work.name_len != hrlp_pkg::MAX_LEN) begin
            work.name_len = work.name_len + 8'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // A record closes at a line end or at the end of the buffer.
  assign fin = (work.phase != hrlp_pkg::PH_IDLE) && (eol || s1_last_r);
  assign emit = fin || s1_last_r;
  assign rec_ok = !work.err && (work.phase == hrlp_pkg::PH_NAME) && !work.prev_dot;

  // Result fields.
  always_comb begin
    res_status = hrlp_pkg::ST_EOF;
    res_addr = 32'd0;
    res_len = 8'd0;
    res_labels = 7'd0;
    if (fin && rec_ok) begin
      res_status = hrlp_pkg::ST_OK;
      res_addr = work.addr;
      res_len = work.name_len;
      res_labels = work.labels;
    end else if (fin) begin
      res_status = hrlp_pkg::ST_INVALID;
    end
  end

  // Next record state.
  always_comb begin
    state_nxt = emit ? hrlp_pkg::REC_CLEAR : work;
  end

  // Handshake control.
  assign out_free = !out_valid_r || out_chan.ready;
  assign s1_fire = s1_valid_r && (!emit || out_free);
  assign in_chan.ready = !s1_valid_r || s1_fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_byte_r <= in_chan.text_byte;
      s1_last_r <= in_chan.buffer_last;
    end
  end

  // Record state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hrlp_pkg::REC_CLEAR;
    end else if (s1_fire) begin
      state_r <= state_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit && out_free) begin
      out_status_r <= res_status;
      out_addr_r <= res_addr;
      out_len_r <= res_len;
      out_labels_r <= res_labels;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.status = out_status_r;
  assign out_chan.ipv4_address = out_addr_r;
  assign out_chan.name_length = out_len_r;
  assign out_chan.label_count = out_labels_r;

  // Checks.
  `ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_valid_r && !s1_valid_r, "reset left a request pending")
  `ASSERT_CLK(a_bad_zero, clk, rst_n, out_valid_r && (out_status_r != hrlp_pkg::ST_OK) |-> (out_addr_r == 32'd0) && (out_len_r == 8'd0) && (out_labels_r == 7'd0), "non-okay result carries values")
  `ASSERT_CLK(a_name_dots, clk, rst_n, (state_r.phase == hrlp_pkg::PH_NAME) |-> (state_r.dots == hrlp_pkg::LAST_DOT), "name phase without four groups")
  `ASSERT_CLK(a_idle_clear, clk, rst_n, (state_r.phase == hrlp_pkg::PH_IDLE) |-> (state_r == hrlp_pkg::REC_CLEAR), "idle with stale record state")
  `ASSERT_CLK(a_labels_le_len, clk, rst_n, 8'(state_r.labels) <= state_r.name_len, "more labels than name bytes")

endmodule
